// ----- design/socks_pkg.sv -----
// socks_pkg: types and constants shared by the proxy request parser and its checker
// depends on nothing
`default_nettype none

package socks_pkg;

  // parse phase, one-hot
  typedef enum logic [7:0] {
    PH_VER   = 8'b0000_0001,
    PH_CMD   = 8'b0000_0010,
    PH_RSV   = 8'b0000_0100,
    PH_ATYP  = 8'b0000_1000,
    PH_IPV4  = 8'b0001_0000,
    PH_DLEN  = 8'b0010_0000,
    PH_DNAME = 8'b0100_0000,
    PH_PORT  = 8'b1000_0000
  } phase_e;

  // result event codes
  localparam logic [1:0] EV_BYTE  = 2'd0;
  localparam logic [1:0] EV_CHAR  = 2'd1;
  localparam logic [1:0] EV_DONE  = 2'd2;
  localparam logic [1:0] EV_ERROR = 2'd3;

  // protocol byte values
  localparam logic [7:0] VER_5        = 8'h05;
  localparam logic [7:0] CMD_CONNECT  = 8'h01;
  localparam logic [7:0] RSV_ZERO     = 8'h00;
  localparam logic [7:0] ATYP_IPV4    = 8'h01;
  localparam logic [7:0] ATYP_DOMAIN  = 8'h03;
  localparam logic [7:0] ATYP_IPV6    = 8'h04;

  // reply codes
  localparam logic [3:0] REP_OK        = 4'h0;
  localparam logic [3:0] REP_CMD_UNSUP = 4'h7;
  localparam logic [3:0] REP_ATYP_UNSUP = 4'h8;

  // byte counts of the fixed-size fields
  localparam logic [7:0] IPV4_BYTES = 8'd4;
  localparam logic [7:0] PORT_BYTES = 8'd2;

endpackage

`default_nettype wire

// ----- design/socks5_request_parser.sv -----
// socks5_request_parser: byte-wide parser of the client connect request of a proxy handshake
// depends on socks_pkg
// output: each result is registered and appears in the cycle after its byte is accepted
// throughput: one byte per cycle; a byte is taken while the previous result waits
//   (the input side stalls only when the output register is full and stalled)
// reset: rst_ni, asynchronous, active low; parser returns to the version byte,
//   all request state is cleared and the output register is emptied
`default_nettype none

module socks5_request_parser
  import socks_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request byte stream
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  // one result per request byte
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       event_res_o,
  output logic [3:0]       reply_code_o,
  output logic             addr_is_domain_o,
  output logic [31:0]      ipv4_addr_o,
  output logic [7:0]       domain_length_o,
  output logic [7:0]       domain_char_o,
  output logic [7:0]       domain_index_o,
  output logic [15:0]      dst_port_o
);

  // ---------------------------------------------------------------------------
  // parser state
  // ---------------------------------------------------------------------------
  phase_e       phase_q, phase_d;
  logic [3:0]   reply_q, reply_d;
  logic         dom_q, dom_d;
  logic [31:0]  addr_q, addr_d;
  logic [7:0]   cnt_q, cnt_d;     // bytes taken in the current field
  logic [7:0]   nlen_q, nlen_d;   // declared domain length
  logic [15:0]  port_q, port_d;

  // values after this byte, before a restart wipes them
  phase_e       phase_u;
  logic [3:0]   reply_u;
  logic         dom_u;
  logic [31:0]  addr_u;
  logic [7:0]   cnt_u;
  logic [7:0]   nlen_u;
  logic [15:0]  port_u;
  logic [7:0]   cnt_inc;

  logic [1:0]   ev;
  logic [7:0]   ch, idx;
  logic [15:0]  port_res;
  logic         restart;

  // handshake: the input is held back only while a finished result is stuck
  logic         accept;

  assign in_stall_o = out_valid_o && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign cnt_inc    = cnt_q + 8'd1;

  // ---------------------------------------------------------------------------
  // one byte of parsing
  // ---------------------------------------------------------------------------
  always_comb begin
    phase_u  = phase_q;
    reply_u  = reply_q;
    dom_u    = dom_q;
    addr_u   = addr_q;
    cnt_u    = cnt_q;
    nlen_u   = nlen_q;
    port_u   = port_q;
    ev       = EV_BYTE;
    ch       = 8'd0;
    idx      = 8'd0;
    port_res = 16'd0;
    restart  = 1'b0;

    case (phase_q)
      PH_CMD: begin
        // unsupported command is recorded, parsing carries on
        if (data_byte_i != CMD_CONNECT) reply_u = REP_CMD_UNSUP;
        phase_u = PH_RSV;
      end
      PH_RSV: begin
        if (data_byte_i != RSV_ZERO) reply_u = REP_CMD_UNSUP;
        phase_u = PH_ATYP;
      end
      PH_ATYP: begin
        if (data_byte_i == ATYP_IPV4) begin
          dom_u   = 1'b0;
          cnt_u   = 8'd0;
          phase_u = PH_IPV4;
        end else if (data_byte_i == ATYP_DOMAIN) begin
          dom_u   = 1'b1;
          phase_u = PH_DLEN;
        end else if (data_byte_i == ATYP_IPV6) begin
          // ipv6 ends the request at once with its own reply code
          reply_u = REP_ATYP_UNSUP;
          ev      = EV_DONE;
          restart = 1'b1;
        end else begin
          ev      = EV_ERROR;
          restart = 1'b1;
        end
      end
      PH_IPV4: begin
        // first byte ends up most significant
        addr_u = {addr_q[23:0], data_byte_i};
        if (cnt_inc >= IPV4_BYTES) begin
          cnt_u   = 8'd0;
          phase_u = PH_PORT;
        end else begin
          cnt_u = cnt_inc;
        end
      end
      PH_DLEN: begin
        nlen_u  = data_byte_i;
        cnt_u   = 8'd0;
        // an empty name goes straight to the port
        phase_u = (data_byte_i == 8'd0) ? PH_PORT : PH_DNAME;
      end
      PH_DNAME: begin
        ev  = EV_CHAR;
        ch  = data_byte_i;
        idx = cnt_q;
        if (cnt_inc >= nlen_q) begin
          cnt_u   = 8'd0;
          phase_u = PH_PORT;
        end else begin
          cnt_u = cnt_inc;
        end
      end
      PH_PORT: begin
        // big-endian port
        port_u = {port_q[7:0], data_byte_i};
        cnt_u  = cnt_inc;
        if (cnt_inc >= PORT_BYTES) begin
          ev       = EV_DONE;
          port_res = port_u;
          restart  = 1'b1;
        end
      end
      default: begin
        // version byte; any stray phase code is handled the same way
        if (data_byte_i == VER_5) begin
          phase_u = PH_CMD;
          reply_u = REP_OK;
          dom_u   = 1'b0;
          addr_u  = 32'd0;
          cnt_u   = 8'd0;
          nlen_u  = 8'd0;
          port_u  = 16'd0;
        end else begin
          ev      = EV_ERROR;
          restart = 1'b1;
        end
      end
    endcase

    // a finished or broken request drops everything and waits for a version byte
    if (restart) begin
      phase_d = PH_VER;
      reply_d = REP_OK;
      dom_d   = 1'b0;
      addr_d  = 32'd0;
      cnt_d   = 8'd0;
      nlen_d  = 8'd0;
      port_d  = 16'd0;
    end else begin
      phase_d = phase_u;
      reply_d = reply_u;
      dom_d   = dom_u;
      addr_d  = addr_u;
      cnt_d   = cnt_u;
      nlen_d  = nlen_u;
      port_d  = port_u;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_VER;
      reply_q <= REP_OK;
      dom_q   <= 1'b0;
      addr_q  <= 32'd0;
      cnt_q   <= 8'd0;
      nlen_q  <= 8'd0;
      port_q  <= 16'd0;
    end else if (accept) begin
      phase_q <= phase_d;
      reply_q <= reply_d;
      dom_q   <= dom_d;
      addr_q  <= addr_d;
      cnt_q   <= cnt_d;
      nlen_q  <= nlen_d;
      port_q  <= port_d;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload needs no reset; a protocol error zeroes every field but the event
  always_ff @(posedge clk_i) begin
    if (accept) begin
      event_res_o <= ev;
      if (ev == EV_ERROR) begin
        reply_code_o     <= 4'd0;
        addr_is_domain_o <= 1'b0;
        ipv4_addr_o      <= 32'd0;
        domain_length_o  <= 8'd0;
        domain_char_o    <= 8'd0;
        domain_index_o   <= 8'd0;
        dst_port_o       <= 16'd0;
      end else begin
        reply_code_o     <= reply_u;
        addr_is_domain_o <= dom_u;
        ipv4_addr_o      <= addr_u;
        domain_length_o  <= nlen_u;
        domain_char_o    <= ch;
        domain_index_o   <= idx;
        dst_port_o       <= port_res;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ----- design/socks_checker.sv -----
// socks_checker: port-level checks of the proxy request parser, bound to its top level
// depends on socks_pkg
`default_nettype none

module socks_checker
  import socks_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [1:0]  event_res_o,
  input wire logic [3:0]  reply_code_o,
  input wire logic        addr_is_domain_o,
  input wire logic [31:0] ipv4_addr_o,
  input wire logic [7:0]  domain_length_o,
  input wire logic [7:0]  domain_char_o,
  input wire logic [7:0]  domain_index_o,
  input wire logic [15:0] dst_port_o
);

  // a stalled result holds its event and port
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(event_res_o) && $stable(dst_port_o))
    else $error("stalled request result changed");

  // input is held back only while a result is stuck at the output
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall without a stuck result");

  // protocol error carries nothing but the event
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o == EV_ERROR |->
      reply_code_o == 4'd0 && !addr_is_domain_o && ipv4_addr_o == 32'd0 &&
      domain_length_o == 8'd0 && dst_port_o == 16'd0)
    else $error("error result with nonzero fields");

  // name characters only on character events, port only on completion
  a_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o != EV_CHAR |-> domain_char_o == 8'd0 && domain_index_o == 8'd0)
    else $error("domain character outside a character event");

  a_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o != EV_DONE |-> dst_port_o == 16'd0)
    else $error("port shown before request complete");

endmodule

bind socks5_request_parser socks_checker u_socks_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .event_res_o      (event_res_o),
  .reply_code_o     (reply_code_o),
  .addr_is_domain_o (addr_is_domain_o),
  .ipv4_addr_o      (ipv4_addr_o),
  .domain_length_o  (domain_length_o),
  .domain_char_o    (domain_char_o),
  .domain_index_o   (domain_index_o),
  .dst_port_o       (dst_port_o)
);

`default_nettype wire
